@@ sv/pixel_blend_and_fade_unit_assert.svh @@
`ifndef PIXEL_BLEND_AND_FADE_UNIT_ASSERT_SVH
`define PIXEL_BLEND_AND_FADE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define PBF_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pbf assertion failed");
`define PBF_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("pbf assertion failed");
`else
`define PBF_ASSERT(name, clk, rst_n, prop)
`define PBF_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

@@ sv/pbf_pkg.sv @@
package pbf_pkg;

    localparam int CH_W       = 5;
    localparam int CH_NUM     = 3;
    localparam int COLOR_W    = CH_W * CH_NUM;
    localparam int PROD_W     = 2 * CH_W;
    localparam int WEIGHT_W   = 5;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;

    localparam logic [CH_W-1:0]     CH_MAX     = 5'd31;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 5'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WEIGHT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_WEIGHT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_WEIGHT   = 8'd3;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE     = 2'd0,
        MODE_BLEND    = 2'd1,
        MODE_BRIGHTEN = 2'd2,
        MODE_DARKEN   = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                effect_mode;
        logic [WEIGHT_W-1:0]  first_weight;
        logic [WEIGHT_W-1:0]  second_weight;
        logic [WEIGHT_W-1:0]  fade_weight;
    } t_cfg;

endpackage

@@ sv/pixel_blend_and_fade_unit.sv @@
// Color effects on RGB555 pixels: pass-through, alpha blend of two targets,
// brighten or darken, selected by the mode register and the tuser flags. One
// pixel is taken every clock while the output side is not stalled; a result
// passes the input register, then the result register, before it is presented.
// Both registers keep moving while the output side is stalled only as far as
// it has room. Each channel uses four 5x5-bit multiplies between the two
// registers. Configuration is meant to be written while no pixel is in flight.
`include "pixel_blend_and_fade_unit_assert.svh"

module pixel_blend_and_fade_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [14:0] first_color, [29:15] second_color, [31:30] zero
    input  logic [pbf_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [0] second_found, [1] effect_enable
    input  logic [pbf_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [14:0] result_color, [15] zero
    output logic [pbf_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pbf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pbf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CW = pbf_pkg::CH_W;
    localparam int KW = pbf_pkg::COLOR_W;

    pbf_pkg::t_cfg     cfg;
    pbf_pkg::t_mode    op;

    logic              r_in_valid;
    logic [KW-1:0]     r_in_a;
    logic [KW-1:0]     r_in_b;
    logic              r_in_found;
    logic              r_in_en;
    logic              r_out_valid;
    logic [KW-1:0]     r_out_color;

    logic              n_in_valid;
    logic              n_out_valid;
    logic [KW-1:0]     n_out_color;

    logic              out_free;
    logic              s_accept;

    assign o_cfg_ready = 1'b1;

    pbf_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        priority if (!r_in_en) begin
            op = pbf_pkg::MODE_NONE;
        end else if (cfg.effect_mode == pbf_pkg::MODE_BLEND && !r_in_found) begin
            op = pbf_pkg::MODE_NONE;
        end else begin
            op = cfg.effect_mode;
        end
    end

    for (genvar g = 0; g < pbf_pkg::CH_NUM; g++) begin : g_ch
        pbf_channel u_ch (
            .i_cfg (cfg),
            .i_op  (op),
            .i_a   (r_in_a[g*CW +: CW]),
            .i_b   (r_in_b[g*CW +: CW]),
            .o_c   (n_out_color[g*CW +: CW])
        );
    end

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = r_in_valid;
        end
        if (s_axis_tready) begin
            n_in_valid = s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_a     <= s_axis_tdata[KW-1:0];
            r_in_b     <= s_axis_tdata[2*KW-1:KW];
            r_in_found <= s_axis_tuser[0];
            r_in_en    <= s_axis_tuser[1];
        end
        if (out_free && r_in_valid) begin
            r_out_color <= n_out_color;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = pbf_pkg::M_TDATA_W'(r_out_color);

    `PBF_ASSERT(a_weight_clamp, i_clk, i_rst_n,
        (cfg.first_weight <= pbf_pkg::WEIGHT_MAX) &&
        (cfg.second_weight <= pbf_pkg::WEIGHT_MAX) &&
        (cfg.fade_weight <= pbf_pkg::WEIGHT_MAX))
    `PBF_ASSERT(a_accept_fills_input, i_clk, i_rst_n, s_accept |=> r_in_valid)
    `PBF_ASSERT(a_input_moves_on, i_clk, i_rst_n, (r_in_valid && out_free) |=> r_out_valid)
    `PBF_ASSERT(a_no_drop_when_full, i_clk, i_rst_n,
        (r_in_valid && !out_free) |=> (r_in_valid && r_out_valid))

endmodule

@@ sv/pbf_cfg_regs.sv @@
module pbf_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_valid,
    input  logic [pbf_pkg::CFG_IDX_W-1:0]    i_wr_index,
    input  logic [pbf_pkg::CFG_DATA_W-1:0]   i_wr_data,
    output pbf_pkg::t_cfg                    o_cfg
);

    pbf_pkg::t_cfg                  r_cfg;
    pbf_pkg::t_cfg                  n_cfg;
    logic [pbf_pkg::WEIGHT_W-1:0]   wr_weight;

    // weights clamp at 16
    always_comb begin
        wr_weight = i_wr_data[pbf_pkg::WEIGHT_W-1:0];
        if (wr_weight > pbf_pkg::WEIGHT_MAX) begin
            wr_weight = pbf_pkg::WEIGHT_MAX;
        end
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_valid) begin
            priority if (i_wr_index == pbf_pkg::CFG_MODE) begin
                n_cfg.effect_mode = pbf_pkg::t_mode'(i_wr_data[pbf_pkg::MODE_W-1:0]);
            end else if (i_wr_index == pbf_pkg::CFG_FIRST_WEIGHT) begin
                n_cfg.first_weight = wr_weight;
            end else if (i_wr_index == pbf_pkg::CFG_SECOND_WEIGHT) begin
                n_cfg.second_weight = wr_weight;
            end else if (i_wr_index == pbf_pkg::CFG_FADE_WEIGHT) begin
                n_cfg.fade_weight = wr_weight;
            end else begin
                n_cfg = r_cfg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{effect_mode: pbf_pkg::MODE_NONE, default: '0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/pbf_channel.sv @@
module pbf_channel (
    input  pbf_pkg::t_cfg                i_cfg,
    input  pbf_pkg::t_mode               i_op,
    input  logic [pbf_pkg::CH_W-1:0]     i_a,
    input  logic [pbf_pkg::CH_W-1:0]     i_b,
    output logic [pbf_pkg::CH_W-1:0]     o_c
);

    logic [pbf_pkg::PROD_W-1:0]   prod_a;
    logic [pbf_pkg::PROD_W-1:0]   prod_b;
    logic [pbf_pkg::PROD_W-1:0]   blend_sum;
    logic [pbf_pkg::CH_W:0]       blend_q;
    logic [pbf_pkg::CH_W-1:0]     blend_c;
    logic [pbf_pkg::CH_W-1:0]     headroom;
    logic [pbf_pkg::PROD_W-1:0]   prod_up;
    logic [pbf_pkg::CH_W:0]       bright_sum;
    logic [pbf_pkg::PROD_W-1:0]   prod_down;
    logic [pbf_pkg::CH_W-1:0]     dark_c;

    // blend: 31*16 + 31*16 fits in ten bits
    assign prod_a    = pbf_pkg::PROD_W'(i_a) * pbf_pkg::PROD_W'(i_cfg.first_weight);
    assign prod_b    = pbf_pkg::PROD_W'(i_b) * pbf_pkg::PROD_W'(i_cfg.second_weight);
    assign blend_sum = prod_a + prod_b;
    assign blend_q   = blend_sum[pbf_pkg::PROD_W-1:4];
    assign blend_c   = (blend_q > (pbf_pkg::CH_W+1)'(pbf_pkg::CH_MAX))
                       ? pbf_pkg::CH_MAX : blend_q[pbf_pkg::CH_W-1:0];

    // brighten never passes 31
    assign headroom   = pbf_pkg::CH_MAX - i_a;
    assign prod_up    = pbf_pkg::PROD_W'(headroom) * pbf_pkg::PROD_W'(i_cfg.fade_weight);
    assign bright_sum = (pbf_pkg::CH_W+1)'(i_a) + prod_up[pbf_pkg::PROD_W-1:4];

    assign prod_down = pbf_pkg::PROD_W'(i_a) * pbf_pkg::PROD_W'(i_cfg.fade_weight);
    assign dark_c    = i_a - prod_down[pbf_pkg::CH_W+3:4];

    always_comb begin
        unique case (i_op)
            pbf_pkg::MODE_NONE:     o_c = i_a;
            pbf_pkg::MODE_BLEND:    o_c = blend_c;
            pbf_pkg::MODE_BRIGHTEN: o_c = bright_sum[pbf_pkg::CH_W-1:0];
            pbf_pkg::MODE_DARKEN:   o_c = dark_c;
            default:                o_c = i_a;
        endcase
    end

endmodule
